// ----- hw/rtl/wmm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wmm_pkg: shared definitions for the wildcard mask matcher
// Sizes, character codes, internal command codes and the queued command type.
// ----------------------------------------------------------------------------
package wmm_pkg;

    localparam int MASK_LEN    = 64;
    localparam int LEN_W       = $clog2(MASK_LEN + 1);
    localparam int POS_W       = (MASK_LEN > 1) ? $clog2(MASK_LEN) : 1;

    // input function codes
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_MASK  = 2'd1;
    localparam logic [1:0] FUNC_NAME  = 2'd2;
    localparam logic [1:0] FUNC_END   = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // internal command codes
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD    = 3'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 3'd2;
    localparam logic [OP_W-1:0] OP_STEP    = 3'd3;
    localparam logic [OP_W-1:0] OP_FINISH  = 3'd4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [7:0]      ch;
    } cmd_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UC_A && c <= CH_UC_Z)
        begin
            r = c + CASE_OFS;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/wmm_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wmm_front: input acceptance and command classification
// Folds letter case and turns each input transfer into one queued command.
// ----------------------------------------------------------------------------
module wmm_front (
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [1:0]    func,
    input  wire logic [7:0]    ch,
    input  wire logic          q_full,
    output logic               push,
    output wmm_pkg::cmd_t      cmd
);
    import wmm_pkg::*;

    logic [7:0] folded;

    assign folded   = fold_case(ch);
    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        cmd.ch = folded;
        case (func)
            FUNC_START: cmd.op = OP_CLEAR;
            FUNC_MASK:  cmd.op = (folded == CH_NUL) ? OP_RESTART : OP_LOAD;
            FUNC_NAME:  cmd.op = (folded == CH_NUL) ? OP_FINISH : OP_STEP;
            FUNC_END:   cmd.op = OP_FINISH;
            default:    cmd.op = OP_FINISH;
        endcase
    end

endmodule
`default_nettype wire

// ----- hw/rtl/wmm_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wmm_queue: short command queue
// Decouples the front from the back; full and empty come from registers.
// ----------------------------------------------------------------------------
module wmm_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire wmm_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output logic               full,
    output logic               empty,
    output wmm_pkg::cmd_t      head
);
    import wmm_pkg::*;

    cmd_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/wmm_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wmm_back: mask store, position automaton and result register
// One command per cycle unless a held result stalls; carry-chain star closure.
// ----------------------------------------------------------------------------
module wmm_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire wmm_pkg::cmd_t head,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic               matched,
    output logic               overflow
);
    import wmm_pkg::*;

    logic [7:0]          chars_reg [MASK_LEN];
    logic [MASK_LEN-1:0] star_reg;
    logic [MASK_LEN-1:0] star_next;
    logic [MASK_LEN-1:0] used_reg;
    logic [MASK_LEN-1:0] used_next;
    logic [LEN_W-1:0]    len_reg;
    logic [LEN_W-1:0]    len_next;
    logic                ovf_reg;
    logic                ovf_next;
    logic [MASK_LEN:0]   act_reg;
    logic [MASK_LEN:0]   act_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                matched_reg;
    logic                overflow_reg;

    logic                room;
    logic                wr_en;
    logic [MASK_LEN:0]   advanced;
    logic [MASK_LEN:0]   seed;
    logic [MASK_LEN:0]   star_ext;
    logic [MASK_LEN:0]   gen;
    logic [MASK_LEN:0]   sum;
    logic [MASK_LEN:0]   carries;
    logic                is_finish;
    logic                hit;

    assign is_finish = (head.op == OP_FINISH);
    assign pop       = !q_empty && (!is_finish || !out_valid_reg || out_ready);
    assign room      = (len_reg < LEN_W'(MASK_LEN));
    assign wr_en     = pop && (head.op == OP_LOAD) && room;
    assign hit       = act_reg[len_reg] && !ovf_reg;

    // one parallel step over all stored positions
    always_comb
    begin
        advanced = '0;
        for (int i = 0; i < MASK_LEN; i++)
        begin
            if (act_reg[i] && used_reg[i])
            begin
                if (star_reg[i])
                begin
                    advanced[i] = 1'b1;
                end
                else if (head.ch != CH_STAR &&
                         (chars_reg[i] == CH_QMARK || chars_reg[i] == head.ch))
                begin
                    advanced[i+1] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        star_next = star_reg;
        used_next = used_reg;
        len_next  = len_reg;
        ovf_next  = ovf_reg;
        seed      = (MASK_LEN + 1)'(1);
        if (pop)
        begin
            case (head.op)
                OP_CLEAR:
                begin
                    star_next = '0;
                    used_next = '0;
                    len_next  = '0;
                    ovf_next  = 1'b0;
                end
                OP_LOAD:
                begin
                    if (room)
                    begin
                        star_next[len_reg[POS_W-1:0]] = (head.ch == CH_STAR);
                        used_next[len_reg[POS_W-1:0]] = 1'b1;
                        len_next = len_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                OP_STEP:
                begin
                    seed = advanced;
                end
                default:
                begin
                end
            endcase
        end
    end

    // an active star lets the carry run up through the star run that follows
    assign star_ext = {1'b0, star_next};
    assign gen      = seed & star_ext;
    assign sum      = star_ext + gen;
    assign carries  = sum ^ star_ext ^ gen;

    always_comb
    begin
        act_next = act_reg;
        if (pop)
        begin
            act_next = seed | carries;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop && is_finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            star_reg      <= '0;
            used_reg      <= '0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            act_reg       <= (MASK_LEN + 1)'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            star_reg      <= star_next;
            used_reg      <= used_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            act_reg       <= act_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            chars_reg[len_reg[POS_W-1:0]] <= head.ch;
        end
        if (pop && is_finish)
        begin
            matched_reg  <= hit;
            overflow_reg <= ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;
    assign overflow  = overflow_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/wildcard_mask_match.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wildcard_mask_match: case-insensitive wildcard mask matcher
// Front classifies input transfers, a two-entry queue buffers them and the
// back runs the position automaton and holds the result.
// ----------------------------------------------------------------------------
// path: when the queue is empty, the transfer that ends the name is written into
//   the queue, popped by the back and registered with out_valid set
// throughput: one input transfer per cycle, one automaton update per cycle;
//   a held result stalls end-of-name and, once the queue fills, the input
// reset: empty mask, no overflow, automaton at position zero, queue and
//   result register empty; stored mask characters are not cleared
module wildcard_mask_match (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] func,
    input  wire logic [7:0] ch,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            matched,
    output logic            overflow
);
    import wmm_pkg::*;

    cmd_t push_cmd;
    cmd_t head;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    wmm_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .ch       (ch),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    wmm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head)
    );

    wmm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .matched   (matched),
        .overflow  (overflow)
    );

endmodule
`default_nettype wire

// ----- verif/wildcard_mask_match_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wildcard_mask_match_tb: self-checking bench for the wildcard mask matcher
// Loads masks and streams names through the valid/ready input, predicts each
// match verdict with a behavioral automaton of its own and compares every
// result transfer against the oldest pending verdict. Covers directed corner
// cases, a full and an overflowing mask, a long output hold-off and random
// well-formed and broken traffic with random idle and stall bursts.
// ----------------------------------------------------------------------------
module wildcard_mask_match_tb;

    import wmm_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          HOLD_CYCLES  = 300;
    localparam logic [7:0]  CH_LC_A      = 8'h61;
    localparam logic [7:0]  CH_LC_Z      = 8'h7A;

    typedef struct packed {
        logic hit;
        logic ovf;
    } verdict_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] func;
    logic [7:0] ch;
    logic       out_valid;
    logic       out_ready;
    logic       matched;
    logic       overflow;

    // behavioral copy of the matcher state
    logic [7:0]      mask_mem [MASK_LEN];
    int unsigned     mask_cnt = 0;
    bit              mask_ovf = 1'b0;
    bit [MASK_LEN:0] live     = 1;

    verdict_t pending_verdicts [$];

    int mismatch_cnt = 0;
    int items_sent   = 0;
    int cycle_cnt    = 0;
    int hold_req     = 0;
    bit idle_on      = 1'b1;
    bit stall_on     = 1'b1;

    wildcard_mask_match DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .ch        (ch),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .matched   (matched),
        .overflow  (overflow)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d verdicts pending", $time, pending_verdicts.size());
            $display("wildcard_mask_match test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // verdict predictor
    // ------------------------------------------------------------------
    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        if (c >= CH_UC_A && c <= CH_UC_Z)
        begin
            return c + CASE_OFS;
        end
        return c;
    endfunction

    // a live star position also makes the position after it live
    function automatic void spread_stars();
        for (int i = 0; i < mask_cnt; i++)
        begin
            if (live[i] && mask_mem[i] == CH_STAR)
            begin
                live[i+1] = 1'b1;
            end
        end
    endfunction

    function automatic void reset_positions();
        live    = '0;
        live[0] = 1'b1;
        spread_stars();
    endfunction

    function automatic void step_positions(input logic [7:0] c);
        bit [MASK_LEN:0] nxt;
        logic [7:0]      m;
        nxt = '0;
        for (int i = 0; i < mask_cnt; i++)
        begin
            if (live[i])
            begin
                m = mask_mem[i];
                if (m == CH_STAR)
                begin
                    nxt[i] = 1'b1;
                end
                else if (c != CH_STAR && (m == CH_QMARK || m == c))
                begin
                    nxt[i+1] = 1'b1;
                end
            end
        end
        live = nxt;
        spread_stars();
    endfunction

    function automatic void close_name();
        verdict_t v;
        v.hit = live[mask_cnt] && !mask_ovf;
        v.ovf = mask_ovf;
        pending_verdicts.push_back(v);
        reset_positions();
    endfunction

    function automatic void predict_transfer(input logic [1:0] f, input logic [7:0] raw);
        logic [7:0] c;
        c = fold_lower(raw);
        case (f)
            FUNC_START:
            begin
                mask_cnt = 0;
                mask_ovf = 1'b0;
                reset_positions();
            end
            FUNC_MASK:
            begin
                if (c != CH_NUL)
                begin
                    if (mask_cnt < MASK_LEN)
                    begin
                        mask_mem[mask_cnt] = c;
                        mask_cnt++;
                    end
                    else
                    begin
                        mask_ovf = 1'b1;
                    end
                end
                reset_positions();
            end
            FUNC_NAME:
            begin
                if (c == CH_NUL)
                begin
                    close_name();
                end
                else
                begin
                    step_positions(c);
                end
            end
            default:
            begin
                close_name();
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got matched=%b overflow=%b",
                         $time, matched, overflow);
                mismatch_cnt++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (matched !== want.hit)
                begin
                    $display("%0t: matched expected %b got %b", $time, want.hit, matched);
                    mismatch_cnt++;
                end
                if (overflow !== want.ovf)
                begin
                    $display("%0t: overflow expected %b got %b", $time, want.ovf, overflow);
                    mismatch_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result receiver: random stall bursts and requested long hold-offs
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int span;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_req > 0)
            begin
                span     = hold_req;
                hold_req = 0;
                out_ready <= 1'b0;
            end
            else if (stall_on && $urandom_range(0, 3) == 0)
            begin
                span = $urandom_range(1, 4);
                out_ready <= 1'b0;
            end
            else
            begin
                span = 1;
                out_ready <= 1'b1;
            end
            repeat (span) @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // input driving, called at a falling edge, returns at a falling edge
    // ------------------------------------------------------------------
    task automatic send_item(input logic [1:0] f, input logic [7:0] c);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        ch       <= c;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predict_transfer(f, c);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input logic [1:0] f, input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_item(f, s[i]);
        end
    endtask

    function automatic logic [7:0] pick_char(input bit allow_nul);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return CH_LC_A + 8'($urandom_range(0, 2));
            4:          return CH_UC_A + 8'($urandom_range(0, 2));
            5:          return CH_STAR;
            6:          return CH_QMARK;
            7:          return 8'($urandom_range(1, 255));
            // around the folding boundaries
            8:          return 8'($urandom_range(CH_UC_A - 1, CH_LC_Z + 1));
            default:    return (allow_nul && $urandom_range(0, 3) == 0) ?
                               CH_NUL : 8'($urandom_range(1, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed_cases();
        send_item(FUNC_START, 8'hFF);
        // empty mask against the empty name, then against a one-letter name
        send_item(FUNC_END, 8'h00);
        send_item(FUNC_NAME, CH_LC_A);
        send_item(FUNC_END, 8'hFF);
        // upper case mask is folded
        send_text(FUNC_MASK, "A*?");
        send_text(FUNC_NAME, "aB");
        send_item(FUNC_END, 8'h00);
        // question mark never takes a star
        send_text(FUNC_NAME, "a*");
        send_item(FUNC_END, 8'h00);
        send_item(FUNC_MASK, CH_NUL);
        // mask grows while a name is in progress, abandoning it
        send_item(FUNC_NAME, CH_LC_A);
        send_item(FUNC_MASK, CH_UC_Z);
        // name ended by a zero byte
        send_text(FUNC_NAME, "AxZ");
        send_item(FUNC_NAME, CH_NUL);
        send_item(FUNC_NAME, 8'hFF);
        send_item(FUNC_END, 8'h00);
    endtask

    task automatic test_mask_overflow();
        send_item(FUNC_START, 8'h00);
        repeat (MASK_LEN) send_item(FUNC_MASK, CH_QMARK);
        repeat (MASK_LEN) send_item(FUNC_NAME, 8'hFF);
        send_item(FUNC_END, 8'h00);
        repeat (MASK_LEN - 1) send_item(FUNC_NAME, CH_LC_A);
        send_item(FUNC_END, 8'h00);
        // one past the store
        send_item(FUNC_MASK, CH_STAR);
        send_item(FUNC_END, 8'h00);
        send_text(FUNC_NAME, "ab");
        send_item(FUNC_NAME, CH_NUL);
        // start clears the overflow
        send_item(FUNC_START, 8'h00);
        send_item(FUNC_END, 8'h00);
    endtask

    task automatic test_output_hold();
        idle_on  = 1'b0;
        stall_on = 1'b0;
        hold_req = HOLD_CYCLES;
        send_item(FUNC_START, 8'h00);
        send_item(FUNC_MASK, CH_STAR);
        repeat (40)
        begin
            send_item(FUNC_NAME, pick_char(1'b0));
            send_item(FUNC_END, 8'h00);
        end
    endtask

    task automatic load_random_mask();
        int len;
        send_item(FUNC_START, 8'($urandom_range(0, 255)));
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(MASK_LEN - 4, MASK_LEN + 4)
                                           : $urandom_range(0, 8);
        repeat (len) send_item(FUNC_MASK, pick_char(1'b1));
    endtask

    // mostly a name that fits the current mask, sometimes garbled or cut by noise
    task automatic send_random_name();
        logic [7:0] plan [$];
        logic [7:0] m;
        logic [7:0] c;
        bit         garble;
        garble = ($urandom_range(0, 5) == 0);
        for (int i = 0; i < mask_cnt; i++)
        begin
            plan.push_back(mask_mem[i]);
        end
        foreach (plan[i])
        begin
            m = plan[i];
            if (m == CH_STAR)
            begin
                repeat ($urandom_range(0, 3)) send_item(FUNC_NAME, pick_char(1'b0));
                continue;
            end
            if (m == CH_QMARK)
            begin
                c = pick_char(1'b0);
                if (c == CH_STAR)
                begin
                    c = CH_QMARK;
                end
            end
            else
            begin
                c = m;
                if (c >= CH_LC_A && c <= CH_LC_Z && $urandom_range(0, 1) == 1)
                begin
                    c = c - CASE_OFS;
                end
            end
            if (garble && $urandom_range(0, 3) == 0)
            begin
                c = pick_char(1'b0);
            end
            if ($urandom_range(0, 39) == 0)
            begin
                send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
            send_item(FUNC_NAME, c);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            send_item(FUNC_NAME, CH_NUL);
        end
        else
        begin
            send_item(FUNC_END, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random_traffic(input int target);
        int stop_at;
        stop_at = items_sent + target;
        while (items_sent < stop_at)
        begin
            // quiet tail with no idling on either side
            if (stop_at - items_sent < 200)
            begin
                idle_on  = 1'b0;
                stall_on = 1'b0;
            end
            else
            begin
                idle_on  = ($urandom_range(0, 3) != 0);
                stall_on = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 7) == 0)
            begin
                load_random_mask();
            end
            repeat ($urandom_range(1, 4)) send_random_name();
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        func     = FUNC_START;
        ch       = 8'h00;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_mask_overflow();
        test_output_hold();
        idle_on  = 1'b1;
        stall_on = 1'b1;
        test_random_traffic(950);

        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_cnt == 0)
        begin
            $display("wildcard_mask_match test passed");
        end
        else
        begin
            $display("wildcard_mask_match test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
